@@ hdl/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants for the ping-pong sample player.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int DEFAULT_CHUNK_DEPTH = 1024;

  localparam int SAMPLE_W = 8;
  localparam int OPCODE_W = 3;
  localparam int TICK_W   = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [SAMPLE_W-1:0] SILENCE_LEVEL = 8'h80;
  localparam logic [SAMPLE_W-1:0] VOLUME_RESET  = 8'd128;
  localparam logic [TICK_W-1:0]   TPS_RESET     = 4'd4;

  localparam logic [1:0] FREE_NONE = 2'd2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_LENGTH = 3'd2,
    OP_START  = 3'd3,
    OP_STOP   = 3'd4
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VOLUME = 1'b0,
    CFG_TPS    = 1'b1
  } cfg_index_t;

  // What a transaction does to the level register at the tail
  typedef enum logic [1:0] {
    LOAD_NONE    = 2'd0,
    LOAD_SILENCE = 2'd1,
    LOAD_SAMPLE  = 2'd2
  } load_kind_t;

  typedef struct packed {
    logic       is_playing;
    logic [1:0] free_buffer;
    logic       drained;
  } pps_status_t;

endpackage

@@ hdl/pps_scaler.sv @@
// ----------------------------------------------------------------------------
// pps_scaler
// Scales an unsigned sample about the midpoint by volume/255, truncating
// toward zero. Product registered; divide by 255 done after the register.
// ----------------------------------------------------------------------------
module pps_scaler
  import pps_pkg::*;
(
  input  logic                clk,
  input  logic                en,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [SAMPLE_W-1:0] volume,
  output logic [SAMPLE_W-1:0] level
);

  logic signed [8:0]  centered;
  logic signed [17:0] product;
  logic        [16:0] mag;
  logic        [16:0] quot_sum;
  logic        [7:0]  quot;
  logic               neg;

  // Center the sample and multiply by the gain
  assign centered = $signed({1'b0, sample}) - 9'sd128;

  always_ff @(posedge clk) begin
    if (en) begin
      product <= centered * $signed({1'b0, volume});
    end
  end

  // Magnitude divided by 255: exact for values below 65280
  assign neg      = product[17];
  assign mag      = neg ? 17'(-product) : product[16:0];
  assign quot_sum = mag + (mag >> 8) + 17'd1;
  assign quot     = quot_sum[15:8];

  // Restore the sign and shift back to the midpoint
  assign level = SILENCE_LEVEL + (neg ? (~quot + 8'd1) : quot);

endmodule

@@ hdl/ping_pong_sample_player_core.sv @@
// Pipeline: the result of an accepted transaction is registered on m_tdata after
// the sample memory read, the gain multiply and the divide by 255, each one stage.
// Throughput: one transaction per cycle while m_tready stays high.
// Reset: rst (synchronous) stops playback, clears lengths, positions and tick
// count, sets the level to silence and loads default volume and tick rate;
// sample memory contents are not cleared.
// ----------------------------------------------------------------------------
// ping_pong_sample_player_core
// Double-buffered PWM sample player: control state in registers, samples
// in a synchronous memory, scaling in a two-stage pipeline.
// ----------------------------------------------------------------------------
module ping_pong_sample_player_core
  import pps_pkg::*;
#(
  parameter int CHUNK_DEPTH = DEFAULT_CHUNK_DEPTH,
  localparam int PW = $clog2(CHUNK_DEPTH),
  localparam int LW = $clog2(CHUNK_DEPTH + 1),
  localparam int IN_BITS = PW + SAMPLE_W + LW + 1,
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8
)
(
  input  logic                  clk,
  input  logic                  rst,

  input  logic                  s_tvalid,
  output logic                  s_tready,
  // position, sample_value, chunk_length, clear_on_stop, zero pad
  input  logic [IN_TDATA_W-1:0] s_tdata,
  // opcode, buffer_select
  input  logic [OPCODE_W:0]     s_tuser,

  output logic                  m_tvalid,
  input  logic                  m_tready,
  // pwm_level, is_playing, free_buffer, drained, zero pad
  output logic [15:0]           m_tdata,
  // level_set
  output logic                  m_tuser,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SAMPLE_W-1:0]   cfg_data
);

  localparam int AW = $clog2(2 * CHUNK_DEPTH);
  localparam logic [LW-1:0] DEPTH_L = LW'(CHUNK_DEPTH);
  localparam logic [AW-1:0] DEPTH_A = AW'(CHUNK_DEPTH);

  // Input fields
  opcode_t               op;
  logic                  sel;
  logic [PW-1:0]         pos;
  logic [SAMPLE_W-1:0]   sval;
  logic [LW-1:0]         clen;
  logic                  clr;

  assign op   = opcode_t'(s_tuser[OPCODE_W-1:0]);
  assign sel  = s_tuser[OPCODE_W];
  assign pos  = s_tdata[PW-1:0];
  assign sval = s_tdata[PW +: SAMPLE_W];
  assign clen = s_tdata[PW + SAMPLE_W +: LW];
  assign clr  = s_tdata[PW + SAMPLE_W + LW];

  // Configuration registers
  logic [SAMPLE_W-1:0] volume;
  logic [TICK_W-1:0]   tps;

  // Control state
  logic [TICK_W-1:0] tick, tick_next;
  logic              playing, playing_next;
  logic              act, act_next;
  logic [LW-1:0]     rp, rp_next;
  logic [LW-1:0]     len0, len0_next;
  logic [LW-1:0]     len1, len1_next;
  logic [SAMPLE_W-1:0] level;

  // Pipeline
  logic        advance, accept;
  logic        s1_valid, s2_valid;
  load_kind_t  kind, s1_kind, s2_kind;
  pps_status_t status, s1_status, s2_status;

  // Sample memory
  logic [SAMPLE_W-1:0] mem [2 * CHUNK_DEPTH];
  logic [SAMPLE_W-1:0] rd_data;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic                wr_en;

  // Sample-time helpers
  logic [TICK_W:0]   tick_inc;
  logic [LW-1:0]     cur_len, oth_len, samp_len, samp_rp, nl_act, nl_oth;
  logic              samp_act;
  logic [SAMPLE_W-1:0] scaled, new_level;

  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = advance;
  assign accept    = s_tvalid && advance;
  assign cfg_ready = 1'b1;

  assign tick_inc = {1'b0, tick} + {{TICK_W{1'b0}}, 1'b1};
  assign cur_len  = act ? len1 : len0;
  assign oth_len  = act ? len0 : len1;
  assign wr_addr  = (sel ? DEPTH_A : '0) + AW'(pos);

  // Decode the transaction and compute the next control state
  always_comb begin
    tick_next    = tick;
    playing_next = playing;
    act_next     = act;
    rp_next      = rp;
    len0_next    = len0;
    len1_next    = len1;
    kind         = LOAD_NONE;
    wr_en        = 1'b0;
    samp_len     = cur_len;
    samp_rp      = rp;
    samp_act     = act;
    rd_addr      = (act ? DEPTH_A : '0) + AW'(rp);
    if (accept) begin
      unique case (op)
        OP_TICK: begin
          if (playing) begin
            if (tick_inc < {1'b0, tps}) begin
              tick_next = tick_inc[TICK_W-1:0];
            end else begin
              tick_next = '0;
              // Spent buffer: clear its length and swap
              if (cur_len != '0 && rp >= cur_len) begin
                if (act) begin
                  len1_next = '0;
                end else begin
                  len0_next = '0;
                end
                samp_act = ~act;
                samp_rp  = '0;
                samp_len = oth_len;
              end
              act_next = samp_act;
              rd_addr  = (samp_act ? DEPTH_A : '0) + AW'(samp_rp);
              if (samp_rp < samp_len) begin
                kind    = LOAD_SAMPLE;
                rp_next = samp_rp + LW'(1);
              end else begin
                kind    = LOAD_SILENCE;
                rp_next = samp_rp;
              end
            end
          end
        end
        OP_WRITE: begin
          wr_en = (LW'(pos) < DEPTH_L);
        end
        OP_LENGTH: begin
          if (sel) begin
            len1_next = (clen > DEPTH_L) ? DEPTH_L : clen;
          end else begin
            len0_next = (clen > DEPTH_L) ? DEPTH_L : clen;
          end
        end
        OP_START: begin
          if (!playing) begin
            playing_next = 1'b1;
            tick_next    = '0;
          end
        end
        OP_STOP: begin
          if (playing) begin
            playing_next = 1'b0;
            kind         = LOAD_SILENCE;
            if (clr) begin
              tick_next = '0;
              len0_next = '0;
              len1_next = '0;
              act_next  = 1'b0;
              rp_next   = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Status after the transaction
  always_comb begin
    nl_act             = act_next ? len1_next : len0_next;
    nl_oth             = act_next ? len0_next : len1_next;
    status.is_playing  = playing_next;
    status.drained     = (nl_act == '0);
    if (nl_act == '0) begin
      status.free_buffer = {1'b0, act_next};
    end else if (nl_oth == '0) begin
      status.free_buffer = {1'b0, ~act_next};
    end else begin
      status.free_buffer = FREE_NONE;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      volume <= VOLUME_RESET;
      tps    <= TPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_VOLUME: volume <= cfg_data;
        CFG_TPS:    tps    <= cfg_data[TICK_W-1:0];
        default:    ;
      endcase
    end
  end

  // Control state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick    <= '0;
      playing <= 1'b0;
      act     <= 1'b0;
      rp      <= '0;
      len0    <= '0;
      len1    <= '0;
    end else begin
      tick    <= tick_next;
      playing <= playing_next;
      act     <= act_next;
      rp      <= rp_next;
      len0    <= len0_next;
      len1    <= len1_next;
    end
  end

  // Sample memory: write on accept, read held during a stall
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= sval;
    end
    if (advance) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Advance the pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s1_kind  <= LOAD_NONE;
      s2_kind  <= LOAD_NONE;
    end else if (advance) begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s1_kind  <= kind;
      s2_kind  <= s1_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_status <= status;
      s2_status <= s1_status;
    end
  end

  pps_scaler u_scaler (
    .clk    (clk),
    .en     (advance),
    .sample (rd_data),
    .volume (volume),
    .level  (scaled)
  );

  // Update the level register at the tail
  always_comb begin
    unique case (s2_kind)
      LOAD_SAMPLE:  new_level = scaled;
      LOAD_SILENCE: new_level = SILENCE_LEVEL;
      default:      new_level = level;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level    <= SILENCE_LEVEL;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= s2_valid;
      if (s2_valid) begin
        level <= new_level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_valid) begin
      m_tdata <= {4'd0, s2_status.drained, s2_status.free_buffer,
                  s2_status.is_playing, new_level};
      m_tuser <= (s2_kind != LOAD_NONE);
    end
  end

  // A stop result while stopped always carries silence
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser && !m_tdata[8] |-> m_tdata[7:0] == SILENCE_LEVEL)
    else $error("stop result without silence level");

  // Read position never runs past a chunk
  assert property (@(posedge clk) disable iff (rst) rp <= DEPTH_L)
    else $error("read position beyond chunk");

  // Lengths stay saturated to a chunk
  assert property (@(posedge clk) disable iff (rst)
    len0 <= DEPTH_L && len1 <= DEPTH_L)
    else $error("chunk length beyond chunk");

  // An accepted stop while playing leaves the block stopped
  assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_STOP && playing |=> !playing)
    else $error("stop did not halt playback");

  // A level load only follows a playing tick or a stop
  assert property (@(posedge clk) disable iff (rst)
    kind != LOAD_NONE |-> playing)
    else $error("level load while stopped");

endmodule
